FILE: hw/rtl/vsl_pkg.sv
// Shared constants and types for the linear-probe visited set.
package vsl_pkg;

   localparam int ID_W       = 32;
   localparam int HASH_W     = 32;
   localparam int TYPE_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REQ_DATA_W = 72;

   typedef enum logic {
      REQ_ADD   = 1'b0,
      REQ_CLEAR = 1'b1
   } req_kind_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_ITEM_LOW_TYPE_ADDR = 3'd0;

endpackage

FILE: hw/rtl/visited_set_linear_probe.sv
// Visited set with linear probing over one key memory, under a small sequencer.
//
// After reset the block sweeps the slot memory before it takes its first beat; a clear
// request costs the same sweep. An add beat, once taken, probes one slot per cycle through
// the registered read port of the slot memory and then loads the result register.
// When TABLE_SIZE is not a power of two the start slot comes from a reciprocal multiply,
// a back multiply and one correction step on a single shared multiplier. An ignored add
// goes straight to the result register. A finished result waits in the output register
// without holding back the next request; the result of that request waits in ST_RESULT
// until the output register is free.
module visited_set_linear_probe #(
   parameter int TABLE_SIZE = 512
) (
   input  logic clock,
   input  logic reset,

   input  logic                              req_tvalid,
   output logic                              req_tready,
   // item_id [31:0], item_hash [63:32], type_code [71:64]
   input  logic [vsl_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_type [0]
   input  logic                              req_tuser,

   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // newly_added [0], ignored [1], table_full [2], queued_item [34:3], slot_index,
   // entry_total, grow_advised, then zero fill
   output logic [((3+vsl_pkg::ID_W+$clog2(TABLE_SIZE)+$clog2(TABLE_SIZE+1)+1+7)/8)*8-1:0]
                                             rsp_tdata,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vsl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [vsl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [vsl_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int IDX_W   = $clog2(TABLE_SIZE);
   localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
   localparam int RAW_W   = 3 + vsl_pkg::ID_W + IDX_W + CNT_W + 1;
   localparam int RSP_W   = ((RAW_W + 7) / 8) * 8;
   localparam int MUL_W   = 2 * vsl_pkg::HASH_W;
   localparam int MEM_W   = vsl_pkg::ID_W + 1;
   localparam bit POW2    = (TABLE_SIZE == (1 << IDX_W));
   localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W-1:0]   LAST_PRB  = CNT_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W+1:0]   GROW_LIM  = (CNT_W + 2)'(3 * (TABLE_SIZE - 10));
   localparam logic [vsl_pkg::HASH_W-1:0] SIZE_H =
      vsl_pkg::HASH_W'(TABLE_SIZE);
   localparam logic [vsl_pkg::HASH_W-1:0] RECIP =
      vsl_pkg::HASH_W'((64'd1 << vsl_pkg::HASH_W) / TABLE_SIZE);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_HASH,
      ST_FOLD,
      ST_FIX,
      ST_PROBE,
      ST_RESULT
   } state_type;

   state_type                   state_ff, state_in;
   logic [vsl_pkg::TYPE_W-1:0]  low_type_ff, low_type_in;
   logic [vsl_pkg::ID_W-1:0]    id_ff, id_in;
   logic [vsl_pkg::HASH_W-1:0]  hash_ff, hash_in;
   logic [vsl_pkg::HASH_W-1:0]  quo_ff, quo_in;
   logic [IDX_W-1:0]            ix_ff, ix_in;
   logic [CNT_W-1:0]            probe_ff, probe_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            sweep_ff, sweep_in;
   logic                        sweep_rsp_ff, sweep_rsp_in;
   logic                        res_added_ff, res_added_in;
   logic                        res_ign_ff, res_ign_in;
   logic                        res_full_ff, res_full_in;
   logic [IDX_W-1:0]            res_slot_ff, res_slot_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]            rsp_tdata_ff, rsp_tdata_in;

   logic [MEM_W-1:0]            mem [TABLE_SIZE];
   logic [MEM_W-1:0]            rd_ff;
   logic                        mem_we;
   logic [IDX_W-1:0]            mem_waddr;
   logic [MEM_W-1:0]            mem_wdata;
   logic [IDX_W-1:0]            mem_raddr;

   logic [vsl_pkg::ID_W-1:0]    req_id;
   logic [vsl_pkg::HASH_W-1:0]  req_hash;
   logic [vsl_pkg::TYPE_W-1:0]  req_type_code;
   logic [vsl_pkg::HASH_W-1:0]  mul_a;
   logic [vsl_pkg::HASH_W-1:0]  mul_b;
   logic [MUL_W-1:0]            mul_p;
   logic [IDX_W-1:0]            rem_next;
   logic [IDX_W-1:0]            ix_step;
   logic [vsl_pkg::ID_W-1:0]    queued;
   logic                        grow;
   logic                        csr_write;

   assign req_id        = req_tdata[31:0];
   assign req_hash      = req_tdata[63:32];
   assign req_type_code = req_tdata[71:64];

   // One multiplier serves the quotient estimate and the back multiply.
   assign mul_a    = (state_ff == ST_HASH) ? hash_ff : quo_ff;
   assign mul_b    = (state_ff == ST_HASH) ? RECIP : SIZE_H;
   assign mul_p    = MUL_W'(mul_a) * MUL_W'(mul_b);
   assign rem_next = (hash_ff >= SIZE_H) ? IDX_W'(hash_ff - SIZE_H)
                                         : hash_ff[IDX_W-1:0];
   assign ix_step   = (ix_ff == LAST_IDX) ? '0 : ix_ff + IDX_W'(1);

   assign queued = res_added_ff ? id_ff : '0;
   assign grow   = ({count_ff, 2'b00} >= GROW_LIM);

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == vsl_pkg::CSR_ITEM_LOW_TYPE_ADDR)
                       ? vsl_pkg::CSR_DATA_W'(low_type_ff) : '0;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_comb begin
      state_in     = state_ff;
      low_type_in  = low_type_ff;
      id_in        = id_ff;
      hash_in      = hash_ff;
      quo_in       = quo_ff;
      ix_in        = ix_ff;
      probe_in     = probe_ff;
      count_in     = count_ff;
      sweep_in     = sweep_ff;
      sweep_rsp_in = sweep_rsp_ff;
      res_added_in = res_added_ff;
      res_ign_in   = res_ign_ff;
      res_full_in  = res_full_ff;
      res_slot_in  = res_slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_tdata_in = rsp_tdata_ff;
      mem_we       = 1'b0;
      mem_waddr    = ix_ff;
      mem_wdata    = {1'b1, id_ff};
      mem_raddr    = ix_ff;

      if (csr_write && (csr_paddr == vsl_pkg::CSR_ITEM_LOW_TYPE_ADDR)) begin
         low_type_in = csr_pwdata[vsl_pkg::TYPE_W-1:0];
      end

      case (state_ff)
         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            sweep_in  = sweep_ff + IDX_W'(1);
            if (sweep_ff == LAST_IDX) begin
               sweep_rsp_in = 1'b0;
               state_in     = sweep_rsp_ff ? ST_RESULT : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               id_in        = req_id;
               res_added_in = 1'b0;
               res_ign_in   = 1'b0;
               res_full_in  = 1'b0;
               res_slot_in  = '0;
               if (req_tuser == vsl_pkg::REQ_CLEAR) begin
                  count_in     = '0;
                  sweep_in     = '0;
                  sweep_rsp_in = 1'b1;
                  state_in     = ST_SWEEP;
               end else if (req_type_code < low_type_ff) begin
                  res_ign_in = 1'b1;
                  state_in   = ST_RESULT;
               end else begin
                  probe_in = '0;
                  if (POW2) begin
                     ix_in     = req_hash[IDX_W-1:0];
                     mem_raddr = req_hash[IDX_W-1:0];
                     state_in  = ST_PROBE;
                  end else begin
                     hash_in  = req_hash;
                     state_in = ST_HASH;
                  end
               end
            end
         end
         ST_HASH: begin
            quo_in   = mul_p[MUL_W-1:vsl_pkg::HASH_W];
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            hash_in  = hash_ff - mul_p[vsl_pkg::HASH_W-1:0];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            ix_in     = rem_next;
            mem_raddr = rem_next;
            state_in  = ST_PROBE;
         end
         ST_PROBE: begin
            if (!rd_ff[MEM_W-1]) begin
               mem_we       = 1'b1;
               count_in     = count_ff + CNT_W'(1);
               res_added_in = 1'b1;
               res_slot_in  = ix_ff;
               state_in     = ST_RESULT;
            end else if (rd_ff[vsl_pkg::ID_W-1:0] == id_ff) begin
               res_slot_in = ix_ff;
               state_in    = ST_RESULT;
            end else if (probe_ff == LAST_PRB) begin
               res_full_in = 1'b1;
               state_in    = ST_RESULT;
            end else begin
               ix_in     = ix_step;
               mem_raddr = ix_step;
               probe_in  = probe_ff + CNT_W'(1);
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_tdata_in = RSP_W'({grow, count_ff, res_slot_ff, queued,
                                      res_full_ff, res_ign_ff, res_added_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         low_type_ff  <= '0;
         count_ff     <= '0;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_type_ff  <= low_type_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff        <= id_in;
      hash_ff      <= hash_in;
      quo_ff       <= quo_in;
      ix_ff        <= ix_in;
      probe_ff     <= probe_in;
      res_added_ff <= res_added_in;
      res_ign_ff   <= res_ign_in;
      res_full_ff  <= res_full_in;
      res_slot_ff  <= res_slot_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the linear-probe visited set, with its own table model.
`timescale 1ns / 1ps

module tb_top;

   localparam int SLOTS = 512;
   localparam int POOL_SIZE = 300;
   localparam int STALL_LIMIT = 20000;
   // Byte address of the register slot after item_low_type; nothing is decoded there.
   localparam logic [vsl_pkg::CSR_ADDR_W-1:0] CSR_SPARE_ADDR = 3'd4;

   typedef struct packed {
      logic        grow;
      logic [9:0]  total;
      logic [8:0]  slot;
      logic [31:0] queued;
      logic        full;
      logic        ignored;
      logic        added;
   } visit_result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   // item_id [31:0], item_hash [63:32], type_code [71:64]
   logic [vsl_pkg::REQ_DATA_W-1:0] req_tdata;
   // req_type [0]
   logic req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   // newly_added [0], ignored [1], table_full [2], queued_item [34:3], slot_index [43:35],
   // entry_total [53:44], grow_advised [54], zero [55]
   logic [55:0] rsp_tdata;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [vsl_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [vsl_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [vsl_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   bit slot_taken[SLOTS];
   logic [31:0] slot_id[SLOTS];
   int unsigned visited_count;
   logic [7:0] low_type_cfg;
   logic [31:0] pool_id[POOL_SIZE];
   logic [31:0] pool_hash[POOL_SIZE];
   visit_result_type pending_visits[$];
   int mismatches;
   int quiet_cycles;
   bit idle_on;

   visited_set_linear_probe #(.TABLE_SIZE(SLOTS)) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic visit_result_type predict_visit(input vsl_pkg::req_kind_type kind,
                                                      input logic [31:0] id,
                                                      input logic [31:0] hash,
                                                      input logic [7:0] typ);
      visit_result_type r;
      int unsigned ix;
      bit done;
      r = '0;
      done = 1'b0;
      if (kind == vsl_pkg::REQ_CLEAR) begin
         for (int i = 0; i < SLOTS; i++) slot_taken[i] = 1'b0;
         visited_count = 0;
      end else if (typ < low_type_cfg) begin
         r.ignored = 1'b1;
      end else begin
         ix = hash % SLOTS;
         for (int n = 0; n < SLOTS && !done; n++) begin
            if (!slot_taken[ix]) begin
               slot_taken[ix] = 1'b1;
               slot_id[ix] = id;
               visited_count++;
               r.added = 1'b1;
               r.queued = id;
               r.slot = ix[8:0];
               done = 1'b1;
            end else if (slot_id[ix] == id) begin
               r.slot = ix[8:0];
               done = 1'b1;
            end else begin
               ix = (ix + 1) % SLOTS;
            end
         end
         if (!done) r.full = 1'b1;
      end
      r.total = visited_count[9:0];
      r.grow = ((4 * visited_count) / 3 + 10) >= SLOTS;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_results
      visit_result_type got;
      visit_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[54:0];
         if (pending_visits.size() == 0) begin
            $display("%0t: result beat with none expected, actual %0h", $time, got);
            mismatches++;
         end else begin
            want = pending_visits.pop_front();
            compare_field("newly_added", want.added, got.added);
            compare_field("ignored", want.ignored, got.ignored);
            compare_field("table_full", want.full, got.full);
            compare_field("queued_item", want.queued, got.queued);
            compare_field("slot_index", want.slot, got.slot);
            compare_field("entry_total", want.total, got.total);
            compare_field("grow_advised", want.grow, got.grow);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_request(input vsl_pkg::req_kind_type kind, input logic [31:0] id,
                               input logic [31:0] hash, input logic [7:0] typ);
      int gap;
      gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {typ, hash, id};
      do @(posedge clock); while (!req_tready);
      pending_visits.push_back(predict_visit(kind, id, hash, typ));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_visits.size() != 0);
   endtask

   task automatic write_csr(input logic [vsl_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] value);
      wait_for_results();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == vsl_pkg::CSR_ITEM_LOW_TYPE_ADDR) low_type_cfg = value[7:0];
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_mixed(input int count);
      int sel;
      int idx;
      logic [31:0] hash;
      logic [7:0] typ;
      for (int k = 0; k < count; k++) begin
         sel = $urandom_range(0, 99);
         typ = $urandom_range(0, 1) ? 8'($urandom_range(low_type_cfg, 255)) : 8'($urandom);
         if (sel == 0) begin
            send_request(vsl_pkg::REQ_CLEAR, $urandom, $urandom, 8'($urandom));
         end else if (sel < 55) begin
            idx = $urandom_range(0, POOL_SIZE - 1);
            hash = ($urandom_range(0, 9) == 0) ? $urandom : pool_hash[idx];
            send_request(vsl_pkg::REQ_ADD, pool_id[idx], hash, typ);
         end else begin
            send_request(vsl_pkg::REQ_ADD, $urandom, $urandom, typ);
         end
      end
   endtask

   task automatic test_directed();
      write_csr(vsl_pkg::CSR_ITEM_LOW_TYPE_ADDR, 32'd0);
      // The last slot, then a collision there that wraps to slot zero.
      send_request(vsl_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
      send_request(vsl_pkg::REQ_ADD, 32'h0000_0001, 32'h0000_01FF, 8'hFF);
      send_request(vsl_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
      send_request(vsl_pkg::REQ_ADD, 32'h0000_0001, 32'h0000_01FF, 8'h80);
      // An id of zero is an ordinary key.
      send_request(vsl_pkg::REQ_ADD, 32'h0000_0000, 32'h0000_0000, 8'h01);
      send_request(vsl_pkg::REQ_ADD, 32'h0000_0000, 32'h0000_0000, 8'h7F);
      send_request(vsl_pkg::REQ_ADD, 32'hA5A5_A5A5, 32'h8000_0000, 8'h5A);
      send_request(vsl_pkg::REQ_CLEAR, 32'h5A5A_5A5A, 32'h7FFF_FFFF, 8'hA5);
      send_request(vsl_pkg::REQ_ADD, 32'h0000_0001, 32'h0000_01FF, 8'h00);
      write_csr(vsl_pkg::CSR_ITEM_LOW_TYPE_ADDR, 32'hFFFF_FFFF);
      send_request(vsl_pkg::REQ_ADD, 32'h1234_5678, 32'h0000_0010, 8'hFE);
      send_request(vsl_pkg::REQ_ADD, 32'h1234_5678, 32'h0000_0010, 8'hFF);
      send_request(vsl_pkg::REQ_ADD, 32'h8765_4321, 32'h0000_0010, 8'h00);
      // A write to the spare address must leave the threshold alone.
      write_csr(CSR_SPARE_ADDR, 32'd0);
      send_request(vsl_pkg::REQ_ADD, 32'h8765_4321, 32'h0000_0010, 8'hFE);
      write_csr(vsl_pkg::CSR_ITEM_LOW_TYPE_ADDR, 32'd1);
      send_request(vsl_pkg::REQ_ADD, 32'hCAFE_0001, 32'h0000_0011, 8'h00);
      send_request(vsl_pkg::REQ_ADD, 32'hCAFE_0001, 32'h0000_0011, 8'h01);
      write_csr(vsl_pkg::CSR_ITEM_LOW_TYPE_ADDR, 32'd0);
      send_request(vsl_pkg::REQ_ADD, 32'hCAFE_0002, 32'h0000_0011, 8'h00);
      send_request(vsl_pkg::REQ_CLEAR, 32'd0, 32'd0, 8'd0);
   endtask

   task automatic test_fill_to_full();
      logic [31:0] fill_ids[SLOTS];
      logic [31:0] fill_hash[SLOTS];
      int pick;
      write_csr(vsl_pkg::CSR_ITEM_LOW_TYPE_ADDR, 32'd128);
      send_request(vsl_pkg::REQ_CLEAR, $urandom, $urandom, 8'($urandom));
      for (int k = 0; k < SLOTS; k++) begin
         fill_ids[k] = {7'($urandom), k[8:0], 16'($urandom)};
         fill_hash[k] = $urandom;
         if ($urandom_range(0, 9) == 0) fill_hash[k][8:0] = 9'($urandom_range(480, 511));
         send_request(vsl_pkg::REQ_ADD, fill_ids[k], fill_hash[k],
                      8'($urandom_range(128, 255)));
      end
      for (int k = 0; k < 4; k++) begin
         send_request(vsl_pkg::REQ_ADD, {7'($urandom), 9'(k), 16'hFFFF} ^ 32'h0001_0000,
                      $urandom, 8'($urandom_range(128, 255)));
         pick = $urandom_range(0, SLOTS - 1);
         send_request(vsl_pkg::REQ_ADD, fill_ids[pick], fill_hash[pick],
                      8'($urandom_range(128, 255)));
      end
      send_request(vsl_pkg::REQ_ADD, $urandom, $urandom, 8'($urandom_range(0, 127)));
      send_request(vsl_pkg::REQ_CLEAR, $urandom, $urandom, 8'($urandom));
   endtask

   task automatic test_random_mix();
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_id[i] = $urandom;
         pool_hash[i] = $urandom;
      end
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_csr(vsl_pkg::CSR_ITEM_LOW_TYPE_ADDR, 32'd0);
            1: write_csr(vsl_pkg::CSR_ITEM_LOW_TYPE_ADDR, 32'd255);
            2: write_csr(vsl_pkg::CSR_ITEM_LOW_TYPE_ADDR, 32'd1);
            3: write_csr(vsl_pkg::CSR_ITEM_LOW_TYPE_ADDR, 32'd128);
            default: write_csr(vsl_pkg::CSR_ITEM_LOW_TYPE_ADDR, $urandom);
         endcase
         idle_on = (ph % 3 != 2);
         send_mixed(180);
      end
   endtask

   task automatic test_final_steady();
      write_csr(vsl_pkg::CSR_ITEM_LOW_TYPE_ADDR, 32'($urandom_range(0, 64)));
      idle_on = 1'b0;
      send_mixed(210);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      low_type_cfg = 8'd0;
      visited_count = 0;
      mismatches = 0;
      quiet_cycles = 0;
      idle_on = 1'b1;
      for (int i = 0; i < SLOTS; i++) slot_taken[i] = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_to_full();
      test_random_mix();
      test_final_steady();
      wait_for_results();
      // A quiet wait at the end catches any stray result beat.
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_visits.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
